FILE: rtl/mcdw_pkg.sv
package mcdw_pkg;

	// Duty channel indexes
	typedef logic [2:0] ch_idx_t;
	localparam int unsigned NUM_CH = 5;
	localparam ch_idx_t CH_FORWARD = 3'd0;
	localparam ch_idx_t CH_BACK    = 3'd1;
	localparam ch_idx_t CH_TURBO   = 3'd2;
	localparam ch_idx_t CH_LEFT    = 3'd3;
	localparam ch_idx_t CH_RIGHT   = 3'd4;

	typedef logic [7:0] duty_t;

	// Request kind
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_CMD  = 1'b1
	} op_t;

	// Drive command codes; the remaining codes only rearm the watchdog and steer
	typedef enum logic [2:0] {
		CMD_KILL    = 3'd0,
		CMD_STOP    = 3'd1,
		CMD_FORWARD = 3'd2,
		CMD_BACK    = 3'd3,
		CMD_FREQ    = 3'd4
	} cmd_t;

	// Steering codes; the others mean straight
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_TEST_ENABLE     = 3'd0,
		REG_STEP_DELAY      = 3'd1,
		REG_COMMAND_TIMEOUT = 3'd2,
		REG_TURN_DUTY       = 3'd3,
		REG_HALF_DUTY       = 3'd4,
		REG_FULL_DUTY       = 3'd5
	} reg_idx_t;

	// Self-test sequencer, one-hot
	typedef enum logic [5:0] {
		STEP_IDLE    = 6'b000001,
		STEP_LEFT    = 6'b000010,
		STEP_RIGHT   = 6'b000100,
		STEP_FORWARD = 6'b001000,
		STEP_FULL    = 6'b010000,
		STEP_ENDED   = 6'b100000
	} step_t;

endpackage

FILE: rtl/motor_command_decoder_watchdog.sv
// An accepted request passes through the input register and then the duty/state
// registers, which are the result register.
// Throughput: one request per cycle; the decode and both tick counters update in
// one pass, so only a stalled output holds the input side back.
// Reset (arst_n low): all duties and frequency 0, watchdog disarmed, self-test at
// its idle step with its timer armed, configuration at its documented defaults.
module motor_command_decoder_watchdog #(
	parameter int unsigned TICK_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [2:0] command,
	input  logic [7:0] speed,
	input  logic [7:0] turbo,
	input  logic [1:0] direction,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] duty_forward,
	output logic [7:0] duty_back,
	output logic [7:0] duty_turbo,
	output logic [7:0] duty_left,
	output logic [7:0] duty_right,
	output logic [7:0] pwm_frequency
);

	localparam int unsigned CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;

	// Configuration registers
	logic        test_enable_q;
	logic [15:0] step_delay_q;
	logic [15:0] command_timeout_q;
	logic [7:0]  turn_duty_q;
	logic [7:0]  half_duty_q;
	logic [7:0]  full_duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_enable_q     <= 1'b0;
			step_delay_q      <= 16'd1000;
			command_timeout_q <= 16'd500;
			turn_duty_q       <= 8'd255;
			half_duty_q       <= 8'd128;
			full_duty_q       <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcdw_pkg::REG_TEST_ENABLE:     test_enable_q     <= cfg_data[0];
				mcdw_pkg::REG_STEP_DELAY:      step_delay_q      <= cfg_data;
				mcdw_pkg::REG_COMMAND_TIMEOUT: command_timeout_q <= cfg_data;
				mcdw_pkg::REG_TURN_DUTY:       turn_duty_q       <= cfg_data[7:0];
				mcdw_pkg::REG_HALF_DUTY:       half_duty_q       <= cfg_data[7:0];
				mcdw_pkg::REG_FULL_DUTY:       full_duty_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Handshake control
	logic valid_s1;
	logic process;

	assign process  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !process;

	// Input register
	logic       op_s1;
	logic [2:0] command_s1;
	logic [7:0] speed_s1;
	logic [7:0] turbo_s1;
	logic [1:0] direction_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1        <= op;
			command_s1   <= command;
			speed_s1     <= speed;
			turbo_s1     <= turbo;
			direction_s1 <= direction;
		end
	end

	// State / result registers
	mcdw_pkg::duty_t         duty_q [mcdw_pkg::NUM_CH];
	logic [7:0]              freq_q;
	mcdw_pkg::step_t         step_q;
	logic [TICK_BITS-1:0]    tt_q;
	logic                    tt_armed_q;
	logic [TICK_BITS-1:0]    wd_q;
	logic                    wd_armed_q;

	mcdw_pkg::duty_t         duty_d [mcdw_pkg::NUM_CH];
	logic [7:0]              freq_d;
	mcdw_pkg::step_t         step_d;
	logic [TICK_BITS-1:0]    tt_d;
	logic                    tt_armed_d;
	logic [TICK_BITS-1:0]    wd_d;
	logic                    wd_armed_d;
	logic                    rearm;

	// Next-state decode for one request
	always_comb begin
		duty_d     = duty_q;
		freq_d     = freq_q;
		step_d     = step_q;
		tt_d       = tt_q;
		tt_armed_d = tt_armed_q;
		wd_d       = wd_q;
		wd_armed_d = wd_armed_q;
		rearm      = 1'b0;

		if (op_s1 == mcdw_pkg::OP_TICK) begin
			// self-test part first
			if (tt_armed_q && (CMP_W'(tt_q) >= CMP_W'(step_delay_q))) begin
				tt_d = '0;
				unique case (step_q)
					mcdw_pkg::STEP_IDLE: begin
						duty_d = '{default: '0};
						step_d = test_enable_q ? mcdw_pkg::STEP_LEFT : mcdw_pkg::STEP_ENDED;
					end
					mcdw_pkg::STEP_LEFT: begin
						duty_d[mcdw_pkg::CH_RIGHT] = '0;
						duty_d[mcdw_pkg::CH_LEFT]  = turn_duty_q;
						step_d = mcdw_pkg::STEP_RIGHT;
					end
					mcdw_pkg::STEP_RIGHT: begin
						duty_d[mcdw_pkg::CH_LEFT]  = '0;
						duty_d[mcdw_pkg::CH_RIGHT] = turn_duty_q;
						step_d = mcdw_pkg::STEP_FORWARD;
					end
					mcdw_pkg::STEP_FORWARD: begin
						duty_d[mcdw_pkg::CH_BACK]    = '0;
						duty_d[mcdw_pkg::CH_TURBO]   = '0;
						duty_d[mcdw_pkg::CH_FORWARD] = half_duty_q;
						step_d = mcdw_pkg::STEP_FULL;
					end
					mcdw_pkg::STEP_FULL: begin
						duty_d[mcdw_pkg::CH_BACK]    = '0;
						duty_d[mcdw_pkg::CH_FORWARD] = full_duty_q;
						step_d = mcdw_pkg::STEP_IDLE;
					end
					mcdw_pkg::STEP_ENDED: begin
						duty_d     = '{default: '0};
						tt_armed_d = 1'b0;
					end
					default: begin
						duty_d = '{default: '0};
						step_d = mcdw_pkg::STEP_IDLE;
					end
				endcase
			end else if (tt_q != '1) begin
				tt_d = tt_q + TICK_BITS'(1);
			end
			// watchdog part second
			if (wd_armed_q && (CMP_W'(wd_q) >= CMP_W'(command_timeout_q))) begin
				duty_d     = '{default: '0};
				wd_armed_d = 1'b0;
			end else if (wd_q != '1) begin
				wd_d = wd_q + TICK_BITS'(1);
			end
		end else begin
			unique case (command_s1)
				mcdw_pkg::CMD_KILL: begin
					duty_d = '{default: '0};
				end
				mcdw_pkg::CMD_STOP: begin
					duty_d = '{default: '0};
					rearm  = 1'b1;
				end
				mcdw_pkg::CMD_FORWARD: begin
					duty_d[mcdw_pkg::CH_BACK]    = '0;
					duty_d[mcdw_pkg::CH_FORWARD] = speed_s1;
					duty_d[mcdw_pkg::CH_TURBO]   = turbo_s1;
					rearm = 1'b1;
				end
				mcdw_pkg::CMD_BACK: begin
					duty_d[mcdw_pkg::CH_FORWARD] = '0;
					duty_d[mcdw_pkg::CH_TURBO]   = '0;
					duty_d[mcdw_pkg::CH_BACK]    = speed_s1;
					rearm = 1'b1;
				end
				mcdw_pkg::CMD_FREQ: begin
					freq_d = speed_s1;
				end
				default: begin
					rearm = 1'b1;
				end
			endcase
			// watchdog rearm and steering
			if (rearm) begin
				wd_d       = '0;
				wd_armed_d = 1'b1;
				if (direction_s1 == mcdw_pkg::DIR_LEFT) begin
					duty_d[mcdw_pkg::CH_RIGHT] = '0;
					duty_d[mcdw_pkg::CH_LEFT]  = turn_duty_q;
				end else if (direction_s1 == mcdw_pkg::DIR_RIGHT) begin
					duty_d[mcdw_pkg::CH_LEFT]  = '0;
					duty_d[mcdw_pkg::CH_RIGHT] = turn_duty_q;
				end else begin
					duty_d[mcdw_pkg::CH_LEFT]  = '0;
					duty_d[mcdw_pkg::CH_RIGHT] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q     <= '{default: '0};
			freq_q     <= '0;
			step_q     <= mcdw_pkg::STEP_IDLE;
			tt_q       <= '0;
			tt_armed_q <= 1'b1;
			wd_q       <= '0;
			wd_armed_q <= 1'b0;
		end else if (process) begin
			duty_q     <= duty_d;
			freq_q     <= freq_d;
			step_q     <= step_d;
			tt_q       <= tt_d;
			tt_armed_q <= tt_armed_d;
			wd_q       <= wd_d;
			wd_armed_q <= wd_armed_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (process) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	assign duty_forward  = duty_q[mcdw_pkg::CH_FORWARD];
	assign duty_back     = duty_q[mcdw_pkg::CH_BACK];
	assign duty_turbo    = duty_q[mcdw_pkg::CH_TURBO];
	assign duty_left     = duty_q[mcdw_pkg::CH_LEFT];
	assign duty_right    = duty_q[mcdw_pkg::CH_RIGHT];
	assign pwm_frequency = freq_q;

	// Assertions
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(process && op_s1 == mcdw_pkg::OP_CMD && command_s1 != mcdw_pkg::CMD_KILL
			&& command_s1 != mcdw_pkg::CMD_FREQ) |=> (wd_armed_q && wd_q == '0))
		else $error("drive command did not rearm the watchdog");

	a_test_timer_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(tt_armed_q) |-> $past(step_q) == mcdw_pkg::STEP_ENDED)
		else $error("self-test timer disarmed outside the ended step");

	a_freq_only_by_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(freq_q) |-> $past(process && op_s1 == mcdw_pkg::OP_CMD
			&& command_s1 == mcdw_pkg::CMD_FREQ))
		else $error("frequency changed without a set-frequency request");

endmodule

FILE: tb/motor_duty_checker.sv
`timescale 1ns / 100ps

module motor_duty_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       op,
	input  logic [2:0] command,
	input  logic [7:0] speed,
	input  logic [7:0] turbo,
	input  logic [1:0] direction,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] duty_forward,
	input  logic [7:0] duty_back,
	input  logic [7:0] duty_turbo,
	input  logic [7:0] duty_left,
	input  logic [7:0] duty_right,
	input  logic [7:0] pwm_frequency,
	output int         mismatches,
	output int         outstanding
);

	localparam int unsigned TICK_BITS = 16;
	localparam int unsigned NUM_FIELDS = 6;

	typedef logic [TICK_BITS-1:0] ticks_t;
	// forward, back, turbo, left, right, frequency at indexes 0..5
	typedef logic [NUM_FIELDS-1:0][7:0] duty_set_t;

	// configuration copy
	logic   test_enable_q;
	logic [15:0] step_delay_q;
	logic [15:0] cmd_timeout_q;
	mcdw_pkg::duty_t  turn_duty_q;
	mcdw_pkg::duty_t  half_duty_q;
	mcdw_pkg::duty_t  full_duty_q;

	// predicted block state
	mcdw_pkg::step_t  test_step;
	ticks_t test_ticks;
	logic   test_armed;
	ticks_t wd_ticks;
	logic   wd_armed;
	mcdw_pkg::duty_t  duty [mcdw_pkg::NUM_CH];
	mcdw_pkg::duty_t  freq_q;

	duty_set_t expected_duties[$];
	duty_set_t want;
	duty_set_t got;

	function automatic ticks_t count_up(ticks_t v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic string field_label(int i);
		case (i)
			0: return "duty_forward";
			1: return "duty_back";
			2: return "duty_turbo";
			3: return "duty_left";
			4: return "duty_right";
			default: return "pwm_frequency";
		endcase
	endfunction

	task automatic idle_all();
		for (int i = 0; i < mcdw_pkg::NUM_CH; i++)
			duty[i] = '0;
	endtask

	// One step of the self-test sequencer
	task automatic run_test_step();
		case (test_step)
			mcdw_pkg::STEP_IDLE: begin
				idle_all();
				test_step = test_enable_q ? mcdw_pkg::STEP_LEFT
					: mcdw_pkg::STEP_ENDED;
			end
			mcdw_pkg::STEP_LEFT: begin
				duty[mcdw_pkg::CH_RIGHT] = '0;
				duty[mcdw_pkg::CH_LEFT] = turn_duty_q;
				test_step = mcdw_pkg::STEP_RIGHT;
			end
			mcdw_pkg::STEP_RIGHT: begin
				duty[mcdw_pkg::CH_LEFT] = '0;
				duty[mcdw_pkg::CH_RIGHT] = turn_duty_q;
				test_step = mcdw_pkg::STEP_FORWARD;
			end
			mcdw_pkg::STEP_FORWARD: begin
				duty[mcdw_pkg::CH_BACK] = '0;
				duty[mcdw_pkg::CH_TURBO] = '0;
				duty[mcdw_pkg::CH_FORWARD] = half_duty_q;
				test_step = mcdw_pkg::STEP_FULL;
			end
			mcdw_pkg::STEP_FULL: begin
				duty[mcdw_pkg::CH_BACK] = '0;
				duty[mcdw_pkg::CH_FORWARD] = full_duty_q;
				test_step = mcdw_pkg::STEP_IDLE;
			end
			mcdw_pkg::STEP_ENDED: begin
				idle_all();
				test_armed = 1'b0;
			end
			default: begin
				idle_all();
				test_step = mcdw_pkg::STEP_IDLE;
			end
		endcase
	endtask

	// Tick: self-test timer first, then the command watchdog
	task automatic apply_tick();
		if (test_armed && test_ticks >= step_delay_q) begin
			test_ticks = '0;
			run_test_step();
		end else begin
			test_ticks = count_up(test_ticks);
		end
		if (wd_armed && wd_ticks >= cmd_timeout_q) begin
			idle_all();
			wd_armed = 1'b0;
		end else begin
			wd_ticks = count_up(wd_ticks);
		end
	endtask

	task automatic apply_command(logic [2:0] code, mcdw_pkg::duty_t spd,
			mcdw_pkg::duty_t trb, logic [1:0] dir);
		case (code)
			mcdw_pkg::CMD_KILL: begin
				idle_all();
				return;
			end
			mcdw_pkg::CMD_STOP: idle_all();
			mcdw_pkg::CMD_FORWARD: begin
				duty[mcdw_pkg::CH_BACK] = '0;
				duty[mcdw_pkg::CH_FORWARD] = spd;
				duty[mcdw_pkg::CH_TURBO] = trb;
			end
			mcdw_pkg::CMD_BACK: begin
				duty[mcdw_pkg::CH_FORWARD] = '0;
				duty[mcdw_pkg::CH_TURBO] = '0;
				duty[mcdw_pkg::CH_BACK] = spd;
			end
			mcdw_pkg::CMD_FREQ: begin
				freq_q = spd;
				return;
			end
			default: ;
		endcase
		// rearm the watchdog and steer
		wd_ticks = '0;
		wd_armed = 1'b1;
		if (dir == mcdw_pkg::DIR_LEFT) begin
			duty[mcdw_pkg::CH_RIGHT] = '0;
			duty[mcdw_pkg::CH_LEFT] = turn_duty_q;
		end else if (dir == mcdw_pkg::DIR_RIGHT) begin
			duty[mcdw_pkg::CH_LEFT] = '0;
			duty[mcdw_pkg::CH_RIGHT] = turn_duty_q;
		end else begin
			duty[mcdw_pkg::CH_LEFT] = '0;
			duty[mcdw_pkg::CH_RIGHT] = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_enable_q = 1'b0;
			step_delay_q = 16'd1000;
			cmd_timeout_q = 16'd500;
			turn_duty_q = 8'd255;
			half_duty_q = 8'd128;
			full_duty_q = 8'd255;
			test_step = mcdw_pkg::STEP_IDLE;
			test_ticks = '0;
			test_armed = 1'b1;
			wd_ticks = '0;
			wd_armed = 1'b0;
			idle_all();
			freq_q = '0;
			expected_duties.delete();
			mismatches = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (mcdw_pkg::reg_idx_t'(cfg_index))
					mcdw_pkg::REG_TEST_ENABLE:     test_enable_q = cfg_data[0];
					mcdw_pkg::REG_STEP_DELAY:      step_delay_q = cfg_data;
					mcdw_pkg::REG_COMMAND_TIMEOUT: cmd_timeout_q = cfg_data;
					mcdw_pkg::REG_TURN_DUTY:       turn_duty_q = cfg_data[7:0];
					mcdw_pkg::REG_HALF_DUTY:       half_duty_q = cfg_data[7:0];
					mcdw_pkg::REG_FULL_DUTY:       full_duty_q = cfg_data[7:0];
					default: ;
				endcase
			end

			// compare a delivered result with the oldest prediction
			if (out_valid && !out_stall) begin
				got[0] = duty_forward;
				got[1] = duty_back;
				got[2] = duty_turbo;
				got[3] = duty_left;
				got[4] = duty_right;
				got[5] = pwm_frequency;
				if (expected_duties.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request pending, expected none, got %h",
						$time, got);
				end else begin
					want = expected_duties.pop_front();
					for (int i = 0; i < NUM_FIELDS; i++) begin
						if (got[i] !== want[i]) begin
							mismatches++;
							$display("%0t: %s expected %0d, got %0d",
								$time, field_label(i), want[i], got[i]);
						end
					end
				end
			end

			// predict the result of an accepted request
			if (in_valid && !in_stall) begin
				if (op == mcdw_pkg::OP_TICK)
					apply_tick();
				else
					apply_command(command, speed, turbo, direction);
				want[0] = duty[mcdw_pkg::CH_FORWARD];
				want[1] = duty[mcdw_pkg::CH_BACK];
				want[2] = duty[mcdw_pkg::CH_TURBO];
				want[3] = duty[mcdw_pkg::CH_LEFT];
				want[4] = duty[mcdw_pkg::CH_RIGHT];
				want[5] = freq_q;
				expected_duties.push_back(want);
			end
		end
		outstanding = expected_duties.size();
	end

endmodule

FILE: tb/motor_command_decoder_watchdog_test.sv
`timescale 1ns / 100ps

module motor_command_decoder_watchdog_test;

	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned PHASE_ITEMS = 280;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       op;
	logic [2:0] command;
	logic [7:0] speed;
	logic [7:0] turbo;
	logic [1:0] direction;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] duty_forward;
	logic [7:0] duty_back;
	logic [7:0] duty_turbo;
	logic [7:0] duty_left;
	logic [7:0] duty_right;
	logic [7:0] pwm_frequency;

	int mismatches;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles = 0;

	motor_command_decoder_watchdog dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.command(command),
		.speed(speed),
		.turbo(turbo),
		.direction(direction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.duty_forward(duty_forward),
		.duty_back(duty_back),
		.duty_turbo(duty_turbo),
		.duty_left(duty_left),
		.duty_right(duty_right),
		.pwm_frequency(pwm_frequency)
	);

	motor_duty_checker duty_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.command(command),
		.speed(speed),
		.turbo(turbo),
		.direction(direction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.duty_forward(duty_forward),
		.duty_back(duty_back),
		.duty_turbo(duty_turbo),
		.duty_left(duty_left),
		.duty_right(duty_right),
		.pwm_frequency(pwm_frequency),
		.mismatches(mismatches),
		.outstanding(pending)
	);

	always #6 clk = ~clk;

	// random back-pressure on the result side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// stop a hung run: no request moved on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input mcdw_pkg::reg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic te, input logic [15:0] sd, input logic [15:0] ct,
			input mcdw_pkg::duty_t tu, input mcdw_pkg::duty_t hd,
			input mcdw_pkg::duty_t fd);
		write_reg(mcdw_pkg::REG_TEST_ENABLE, {15'd0, te});
		write_reg(mcdw_pkg::REG_STEP_DELAY, sd);
		write_reg(mcdw_pkg::REG_COMMAND_TIMEOUT, ct);
		write_reg(mcdw_pkg::REG_TURN_DUTY, {8'd0, tu});
		write_reg(mcdw_pkg::REG_HALF_DUTY, {8'd0, hd});
		write_reg(mcdw_pkg::REG_FULL_DUTY, {8'd0, fd});
		cfg_we <= 1'b0;
	endtask

	// present one request, idling first at random, and hold it until taken
	task automatic send_request(input mcdw_pkg::op_t kind, input logic [2:0] code,
			input mcdw_pkg::duty_t spd, input mcdw_pkg::duty_t trb,
			input logic [1:0] dir);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		command <= code;
		speed <= spd;
		turbo <= trb;
		direction <= dir;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_tick();
		send_request(mcdw_pkg::OP_TICK, 3'($urandom_range(7)), 8'($urandom),
			8'($urandom), 2'($urandom_range(3)));
	endtask

	task automatic random_requests(input int count);
		mcdw_pkg::op_t kind;
		for (int n = 0; n < count; n++) begin
			kind = ($urandom_range(99) < 55) ? mcdw_pkg::OP_TICK : mcdw_pkg::OP_CMD;
			send_request(kind, 3'($urandom_range(7)), 8'($urandom), 8'($urandom),
				2'($urandom_range(3)));
		end
	endtask

	// hold off the sender until every predicted result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = mcdw_pkg::OP_TICK;
		command = '0;
		speed = '0;
		turbo = '0;
		direction = '0;
		out_stall = 1'b0;
		send_idle_pct = 24;
		recv_idle_pct = 68;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short timers so the self-test and watchdog both act early
		configure(1'b1, 16'd3, 16'd6, 8'd255, 8'd128, 8'd255);

		// every command code, field extremes, each steering code
		send_request(mcdw_pkg::OP_CMD, mcdw_pkg::CMD_FORWARD, 8'd255, 8'd255,
			mcdw_pkg::DIR_LEFT);
		send_request(mcdw_pkg::OP_CMD, mcdw_pkg::CMD_BACK, 8'd255, 8'd255,
			mcdw_pkg::DIR_RIGHT);
		send_request(mcdw_pkg::OP_CMD, mcdw_pkg::CMD_STOP, 8'd255, 8'd0, 2'd3);
		send_request(mcdw_pkg::OP_CMD, mcdw_pkg::CMD_FORWARD, 8'd0, 8'd0, 2'd0);
		send_request(mcdw_pkg::OP_CMD, mcdw_pkg::CMD_KILL, 8'd255, 8'd255,
			mcdw_pkg::DIR_LEFT);
		send_request(mcdw_pkg::OP_CMD, mcdw_pkg::CMD_FREQ, 8'd255, 8'd0,
			mcdw_pkg::DIR_RIGHT);
		send_request(mcdw_pkg::OP_CMD, mcdw_pkg::CMD_FORWARD, 8'd200, 8'd100,
			mcdw_pkg::DIR_LEFT);
		for (int c = mcdw_pkg::CMD_FREQ + 1; c < 8; c++)
			send_request(mcdw_pkg::OP_CMD, 3'(c), 8'd0, 8'd255,
				2'(c - mcdw_pkg::CMD_FREQ));
		send_request(mcdw_pkg::OP_CMD, mcdw_pkg::CMD_FREQ, 8'd0, 8'd255, 2'd0);
		// ticks through self-test steps and a watchdog expiry
		repeat (13) send_tick();

		random_requests(PHASE_ITEMS);

		// zero delays: a step on every tick, watchdog fires on the first tick
		drain_results();
		configure(1'b1, 16'd0, 16'd0, 8'd0, 8'd0, 8'd255);
		random_requests(PHASE_ITEMS);

		send_idle_pct = 68;
		recv_idle_pct = 24;
		drain_results();
		configure(1'b1, 16'($urandom_range(1, 7)), 16'($urandom_range(2, 20)),
			8'($urandom), 8'($urandom), 8'($urandom));
		random_requests(PHASE_ITEMS);

		// self-test disabled: the sequence runs out and its timer stops
		drain_results();
		configure(1'b0, 16'd1, 16'($urandom_range(3, 12)),
			8'($urandom), 8'($urandom), 8'($urandom));
		random_requests(PHASE_ITEMS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		drain_results();
		configure(1'b1, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd0);
		random_requests(PHASE_ITEMS);

		drain_results();
		configure(1'b0, 16'hFFFF, 16'd10, 8'($urandom), 8'($urandom), 8'($urandom));
		random_requests(PHASE_ITEMS);

		drain_results();
		repeat (6) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
